### rtl/assert_macros.svh
// assertion helpers for the rtl files, included by radar_measurement_jacobian_core
// every check is clocked on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define RMJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication check: when ante holds, cons must hold in the same cycle
`define RMJ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/rmj_pkg.sv
// ----------------------------------------------------------------------------
// rmj_pkg
// shared types and constants of the radar measurement jacobian core
// ----------------------------------------------------------------------------
package rmj_pkg;

  // configuration register
  localparam int unsigned CfgW = 32;
  localparam logic [CfgW-1:0] MinRangeSqRst = 32'd7;

  // one quotient lane for each jacobian entry
  localparam int unsigned NumLanes = 6;
  localparam int unsigned LaneRngX = 0;
  localparam int unsigned LaneRngY = 1;
  localparam int unsigned LaneBrgX = 2;
  localparam int unsigned LaneBrgY = 3;
  localparam int unsigned LaneRteX = 4;
  localparam int unsigned LaneRteY = 5;

  // control travelling with each request down the cell chains
  typedef struct packed {
    logic                vld;
    logic                tc;
    logic [NumLanes-1:0] neg;
    logic [NumLanes-1:0] ovf;
  } ctl_t;

endpackage

### rtl/rmj_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rmj_sqrt_cell
// one root bit of the integer square root of r^2, carries the state along
// ----------------------------------------------------------------------------
module rmj_sqrt_cell #(
  parameter int unsigned DW  = 32,
  parameter int unsigned BIT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmj_pkg::ctl_t       ctl_i,
  input  logic [2*DW-1:0]     rem_i,
  input  logic [DW-1:0]       root_i,
  input  logic [2*DW-1:0]     sq_i,
  input  logic [DW-1:0]       xm_i,
  input  logic [DW-1:0]       ym_i,
  input  logic [2*DW-1:0]     cm_i,
  output rmj_pkg::ctl_t       ctl_o,
  output logic [2*DW-1:0]     rem_o,
  output logic [DW-1:0]       root_o,
  output logic [2*DW-1:0]     sq_o,
  output logic [DW-1:0]       xm_o,
  output logic [DW-1:0]       ym_o,
  output logic [2*DW-1:0]     cm_o
);

  localparam int unsigned TW = 2 * DW + 1;

  logic [TW-1:0]     trial;
  logic [TW-1:0]     rem_ext;
  logic              hit;
  logic [2*DW-1:0]   rem_d;
  logic [DW-1:0]     root_d;
  rmj_pkg::ctl_t     ctl_q;
  logic [2*DW-1:0]   rem_q;
  logic [DW-1:0]     root_q;
  logic [2*DW-1:0]   sq_q;
  logic [DW-1:0]     xm_q;
  logic [DW-1:0]     ym_q;
  logic [2*DW-1:0]   cm_q;

  // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
  assign trial   = (TW'(root_i) << (BIT + 1)) | (TW'(1) << (2 * BIT));
  assign rem_ext = TW'(rem_i);
  assign hit     = rem_ext >= trial;
  assign rem_d   = hit ? (2*DW)'(rem_ext - trial) : rem_i;
  assign root_d  = hit ? (root_i | (DW'(1) << BIT)) : root_i;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    sq_q   <= sq_i;
    xm_q   <= xm_i;
    ym_q   <= ym_i;
    cm_q   <= cm_i;
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign sq_o   = sq_q;
  assign xm_o   = xm_q;
  assign ym_o   = ym_q;
  assign cm_o   = cm_q;

endmodule

### rtl/rmj_div_cell.sv
// ----------------------------------------------------------------------------
// rmj_div_cell
// one quotient bit of all six restoring divisions, carries the state along
// ----------------------------------------------------------------------------
module rmj_div_cell #(
  parameter int unsigned DW  = 32,
  parameter int unsigned FW  = 16,
  parameter int unsigned BIT = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmj_pkg::ctl_t                     ctl_i,
  input  logic [DW-1:0]                     rng_den_i,
  input  logic [2*DW-1:0]                   brg_den_i,
  input  logic [3*DW-1:0]                   rte_den_i,
  input  logic [1:0][DW+FW-1:0]             rng_rem_i,
  input  logic [1:0][DW+2*FW-1:0]           brg_rem_i,
  input  logic [1:0][3*DW+FW-1:0]           rte_rem_i,
  input  logic [rmj_pkg::NumLanes-1:0][DW-1:0] quo_i,
  output rmj_pkg::ctl_t                     ctl_o,
  output logic [DW-1:0]                     rng_den_o,
  output logic [2*DW-1:0]                   brg_den_o,
  output logic [3*DW-1:0]                   rte_den_o,
  output logic [1:0][DW+FW-1:0]             rng_rem_o,
  output logic [1:0][DW+2*FW-1:0]           brg_rem_o,
  output logic [1:0][3*DW+FW-1:0]           rte_rem_o,
  output logic [rmj_pkg::NumLanes-1:0][DW-1:0] quo_o
);

  localparam int unsigned NR = DW + FW;
  localparam int unsigned NB = DW + 2 * FW;
  localparam int unsigned NC = 3 * DW + FW;
  localparam int unsigned AR = (NR > DW + BIT) ? NR : DW + BIT;
  localparam int unsigned AB = (NB > 2 * DW + BIT) ? NB : 2 * DW + BIT;
  localparam int unsigned AC = (NC > 3 * DW + BIT) ? NC : 3 * DW + BIT;

  logic [rmj_pkg::NumLanes-1:0]         hit;
  logic [1:0][NR-1:0]                   rng_rem_d;
  logic [1:0][NB-1:0]                   brg_rem_d;
  logic [1:0][NC-1:0]                   rte_rem_d;
  logic [rmj_pkg::NumLanes-1:0][DW-1:0] quo_d;
  rmj_pkg::ctl_t                        ctl_q;
  logic [DW-1:0]                        rng_den_q;
  logic [2*DW-1:0]                      brg_den_q;
  logic [3*DW-1:0]                      rte_den_q;
  logic [1:0][NR-1:0]                   rng_rem_q;
  logic [1:0][NB-1:0]                   brg_rem_q;
  logic [1:0][NC-1:0]                   rte_rem_q;
  logic [rmj_pkg::NumLanes-1:0][DW-1:0] quo_q;

  // trial subtract of the shifted divisor in each lane
  for (genvar j = 0; j < 2; j++) begin : g_lane
    logic [AR-1:0] ra;
    logic [AR-1:0] rd;
    logic [AB-1:0] ba;
    logic [AB-1:0] bd;
    logic [AC-1:0] ca;
    logic [AC-1:0] cd;

    assign ra = AR'(rng_rem_i[j]);
    assign rd = AR'(rng_den_i) << BIT;
    assign ba = AB'(brg_rem_i[j]);
    assign bd = AB'(brg_den_i) << BIT;
    assign ca = AC'(rte_rem_i[j]);
    assign cd = AC'(rte_den_i) << BIT;

    assign hit[rmj_pkg::LaneRngX + j] = ra >= rd;
    assign hit[rmj_pkg::LaneBrgX + j] = ba >= bd;
    assign hit[rmj_pkg::LaneRteX + j] = ca >= cd;

    assign rng_rem_d[j] = hit[rmj_pkg::LaneRngX + j] ? NR'(ra - rd) : rng_rem_i[j];
    assign brg_rem_d[j] = hit[rmj_pkg::LaneBrgX + j] ? NB'(ba - bd) : brg_rem_i[j];
    assign rte_rem_d[j] = hit[rmj_pkg::LaneRteX + j] ? NC'(ca - cd) : rte_rem_i[j];
  end

  // quotient bit insert
  for (genvar k = 0; k < rmj_pkg::NumLanes; k++) begin : g_quo
    assign quo_d[k] = quo_i[k] | (DW'(hit[k]) << BIT);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    rng_den_q <= rng_den_i;
    brg_den_q <= brg_den_i;
    rte_den_q <= rte_den_i;
    rng_rem_q <= rng_rem_d;
    brg_rem_q <= brg_rem_d;
    rte_rem_q <= rte_rem_d;
    quo_q     <= quo_d;
  end

  assign ctl_o     = ctl_q;
  assign rng_den_o = rng_den_q;
  assign brg_den_o = brg_den_q;
  assign rte_den_o = rte_den_q;
  assign rng_rem_o = rng_rem_q;
  assign brg_rem_o = brg_rem_q;
  assign rte_rem_o = rte_rem_q;
  assign quo_o     = quo_q;

endmodule

### rtl/radar_measurement_jacobian_core.sv
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_core
// jacobian of range, bearing and range rate for a planar state, one request
// per cycle through a square root chain and a divider chain
// ----------------------------------------------------------------------------
// channel   | direction | handshake                    | payload
// request   | in        | start_i while busy_o is low  | pos_x_i pos_y_i vel_x_i vel_y_i
// result    | out       | result_valid_o for one cycle | six jacobian entries, too_close_o
// config    | in        | cfg_we_i                     | cfg_wdata_i (min_range_sq)
//
// a request is taken every cycle; busy_o stays low
// the result passes stages a to c, the square root chain, stages d to f, the divider chain
// and stage g, one square root cell per root bit and one divider cell per quotient bit
// reset clears the valid bits of every stage and loads min_range_sq with 7
// the receiver cannot stall, so results are never held
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module radar_measurement_jacobian_core #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [DATA_WIDTH-1:0]  pos_x_i,
  input  logic signed [DATA_WIDTH-1:0]  pos_y_i,
  input  logic signed [DATA_WIDTH-1:0]  vel_x_i,
  input  logic signed [DATA_WIDTH-1:0]  vel_y_i,
  input  logic                          cfg_we_i,
  input  logic [rmj_pkg::CfgW-1:0]      cfg_wdata_i,
  output logic                          result_valid_o,
  output logic signed [DATA_WIDTH-1:0]  range_dpx_o,
  output logic signed [DATA_WIDTH-1:0]  range_dpy_o,
  output logic signed [DATA_WIDTH-1:0]  bearing_dpx_o,
  output logic signed [DATA_WIDTH-1:0]  bearing_dpy_o,
  output logic signed [DATA_WIDTH-1:0]  rate_dpx_o,
  output logic signed [DATA_WIDTH-1:0]  rate_dpy_o,
  output logic                          too_close_o
);

  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned FW  = FRAC_BITS;
  localparam int unsigned NR  = DW + FW;
  localparam int unsigned NB  = DW + 2 * FW;
  localparam int unsigned NC  = 3 * DW + FW;
  localparam int unsigned THW = (2 * DW > rmj_pkg::CfgW + FW) ? 2 * DW : rmj_pkg::CfgW + FW;
  localparam int unsigned LAT = 2 * DW + 7;
  localparam int unsigned NL  = rmj_pkg::NumLanes;
  localparam logic [DW-1:0] HALF = DW'(1) << (DW - 1);

  // configuration register
  logic [rmj_pkg::CfgW-1:0] min_range_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_sq_q <= rmj_pkg::MinRangeSqRst;
    end else if (cfg_we_i) begin
      min_range_sq_q <= cfg_wdata_i;
    end
  end

  assign busy_o = 1'b0;

  // stage a: sign and magnitude of the inputs
  logic            vld_a_q;
  logic [DW-1:0]   xm_a_q, ym_a_q, vxm_a_q, vym_a_q;
  logic            nx_a_q, ny_a_q, nvx_a_q, nvy_a_q;
  logic [DW-1:0]   px_raw, py_raw, vx_raw, vy_raw;

  assign px_raw = pos_x_i;
  assign py_raw = pos_y_i;
  assign vx_raw = vel_x_i;
  assign vy_raw = vel_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_a_q  <= px_raw[DW-1];
    ny_a_q  <= py_raw[DW-1];
    nvx_a_q <= vx_raw[DW-1];
    nvy_a_q <= vy_raw[DW-1];
    xm_a_q  <= px_raw[DW-1] ? (~px_raw + DW'(1)) : px_raw;
    ym_a_q  <= py_raw[DW-1] ? (~py_raw + DW'(1)) : py_raw;
    vxm_a_q <= vx_raw[DW-1] ? (~vx_raw + DW'(1)) : vx_raw;
    vym_a_q <= vy_raw[DW-1] ? (~vy_raw + DW'(1)) : vy_raw;
  end

  // stage b: squares and cross products
  logic            vld_b_q;
  logic [2*DW-1:0] xx_b_q, yy_b_q, m1_b_q, m2_b_q;
  logic [DW-1:0]   xm_b_q, ym_b_q;
  logic            nx_b_q, ny_b_q, n1_b_q, n2_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xx_b_q <= (2*DW)'(xm_a_q) * (2*DW)'(xm_a_q);
    yy_b_q <= (2*DW)'(ym_a_q) * (2*DW)'(ym_a_q);
    m1_b_q <= (2*DW)'(vxm_a_q) * (2*DW)'(ym_a_q);
    m2_b_q <= (2*DW)'(vym_a_q) * (2*DW)'(xm_a_q);
    xm_b_q <= xm_a_q;
    ym_b_q <= ym_a_q;
    nx_b_q <= nx_a_q;
    ny_b_q <= ny_a_q;
    n1_b_q <= nvx_a_q ^ ny_a_q;
    n2_b_q <= !(nvy_a_q ^ nx_a_q);
  end

  // stage c: r^2, cross term, threshold test and output signs
  logic [2*DW-1:0] s_c;
  logic [2*DW-1:0] cm_c;
  logic            nc_c;
  logic            tc_c;
  rmj_pkg::ctl_t   ctl_c;
  rmj_pkg::ctl_t   ctl_c_q;
  logic [2*DW-1:0] s_c_q, cm_c_q;
  logic [DW-1:0]   xm_c_q, ym_c_q;

  assign s_c  = xx_b_q + yy_b_q;
  assign tc_c = (THW'(s_c) < (THW'(min_range_sq_q) << FW)) || (s_c == '0);

  always_comb begin
    if (n1_b_q == n2_b_q) begin
      cm_c = m1_b_q + m2_b_q;
      nc_c = n1_b_q;
    end else if (m1_b_q >= m2_b_q) begin
      cm_c = m1_b_q - m2_b_q;
      nc_c = n1_b_q;
    end else begin
      cm_c = m2_b_q - m1_b_q;
      nc_c = n2_b_q;
    end
  end

  always_comb begin
    ctl_c                         = '0;
    ctl_c.vld                     = vld_b_q;
    ctl_c.tc                      = tc_c;
    ctl_c.neg[rmj_pkg::LaneRngX]  = nx_b_q;
    ctl_c.neg[rmj_pkg::LaneRngY]  = ny_b_q;
    ctl_c.neg[rmj_pkg::LaneBrgX]  = !ny_b_q;
    ctl_c.neg[rmj_pkg::LaneBrgY]  = nx_b_q;
    ctl_c.neg[rmj_pkg::LaneRteX]  = ny_b_q ^ nc_c;
    ctl_c.neg[rmj_pkg::LaneRteY]  = !(nx_b_q ^ nc_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c_q <= '0;
    end else begin
      ctl_c_q <= ctl_c;
    end
  end

  always_ff @(posedge clk_i) begin
    s_c_q  <= s_c;
    cm_c_q <= cm_c;
    xm_c_q <= xm_b_q;
    ym_c_q <= ym_b_q;
  end

  // square root chain, one cell per root bit from the top down
  rmj_pkg::ctl_t   sq_ctl  [DW+1];
  logic [2*DW-1:0] sq_rem  [DW+1];
  logic [DW-1:0]   sq_root [DW+1];
  logic [2*DW-1:0] sq_s    [DW+1];
  logic [DW-1:0]   sq_xm   [DW+1];
  logic [DW-1:0]   sq_ym   [DW+1];
  logic [2*DW-1:0] sq_cm   [DW+1];

  assign sq_ctl[0]  = ctl_c_q;
  assign sq_rem[0]  = s_c_q;
  assign sq_root[0] = '0;
  assign sq_s[0]    = s_c_q;
  assign sq_xm[0]   = xm_c_q;
  assign sq_ym[0]   = ym_c_q;
  assign sq_cm[0]   = cm_c_q;

  for (genvar k = 0; k < DW; k++) begin : g_sqrt
    rmj_sqrt_cell #(
      .DW  (DW),
      .BIT (DW - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (sq_ctl[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .sq_i   (sq_s[k]),
      .xm_i   (sq_xm[k]),
      .ym_i   (sq_ym[k]),
      .cm_i   (sq_cm[k]),
      .ctl_o  (sq_ctl[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .sq_o   (sq_s[k+1]),
      .xm_o   (sq_xm[k+1]),
      .ym_o   (sq_ym[k+1]),
      .cm_o   (sq_cm[k+1])
    );
  end

  // stage d: partial products of y*c, x*c and r^2*r
  rmj_pkg::ctl_t   ctl_d_q;
  logic [2*DW-1:0] yc_lo_d_q, yc_hi_d_q, xc_lo_d_q, xc_hi_d_q, sr_lo_d_q, sr_hi_d_q;
  logic [DW-1:0]   xm_d_q, ym_d_q, r_d_q;
  logic [2*DW-1:0] s_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_d_q <= '0;
    end else begin
      ctl_d_q <= sq_ctl[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    yc_lo_d_q <= (2*DW)'(sq_ym[DW]) * (2*DW)'(sq_cm[DW][DW-1:0]);
    yc_hi_d_q <= (2*DW)'(sq_ym[DW]) * (2*DW)'(sq_cm[DW][2*DW-1:DW]);
    xc_lo_d_q <= (2*DW)'(sq_xm[DW]) * (2*DW)'(sq_cm[DW][DW-1:0]);
    xc_hi_d_q <= (2*DW)'(sq_xm[DW]) * (2*DW)'(sq_cm[DW][2*DW-1:DW]);
    sr_lo_d_q <= (2*DW)'(sq_s[DW][DW-1:0]) * (2*DW)'(sq_root[DW]);
    sr_hi_d_q <= (2*DW)'(sq_s[DW][2*DW-1:DW]) * (2*DW)'(sq_root[DW]);
    xm_d_q    <= sq_xm[DW];
    ym_d_q    <= sq_ym[DW];
    r_d_q     <= sq_root[DW];
    s_d_q     <= sq_s[DW];
  end

  // stage e: sum the partial products
  rmj_pkg::ctl_t   ctl_e_q;
  logic [3*DW-1:0] yc_e_q, xc_e_q, sr_e_q;
  logic [DW-1:0]   xm_e_q, ym_e_q, r_e_q;
  logic [2*DW-1:0] s_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_e_q <= '0;
    end else begin
      ctl_e_q <= ctl_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    yc_e_q <= (3*DW)'(yc_lo_d_q) + ((3*DW)'(yc_hi_d_q) << DW);
    xc_e_q <= (3*DW)'(xc_lo_d_q) + ((3*DW)'(xc_hi_d_q) << DW);
    sr_e_q <= (3*DW)'(sr_lo_d_q) + ((3*DW)'(sr_hi_d_q) << DW);
    xm_e_q <= xm_d_q;
    ym_e_q <= ym_d_q;
    r_e_q  <= r_d_q;
    s_e_q  <= s_d_q;
  end

  // stage f: dividends and overflow test against divisor * 2^DW
  logic [1:0][NR-1:0] rng_num;
  logic [1:0][NB-1:0] brg_num;
  logic [1:0][NC-1:0] rte_num;
  logic [NL-1:0]      ovf_f;
  rmj_pkg::ctl_t      ctl_f;
  rmj_pkg::ctl_t      ctl_f_q;
  logic [1:0][NR-1:0] rng_num_q;
  logic [1:0][NB-1:0] brg_num_q;
  logic [1:0][NC-1:0] rte_num_q;
  logic [DW-1:0]      r_f_q;
  logic [2*DW-1:0]    s_f_q;
  logic [3*DW-1:0]    sr_f_q;

  assign rng_num[0] = NR'(xm_e_q) << FW;
  assign rng_num[1] = NR'(ym_e_q) << FW;
  assign brg_num[0] = NB'(ym_e_q) << (2 * FW);
  assign brg_num[1] = NB'(xm_e_q) << (2 * FW);
  assign rte_num[0] = NC'(yc_e_q) << FW;
  assign rte_num[1] = NC'(xc_e_q) << FW;

  for (genvar j = 0; j < 2; j++) begin : g_ovf
    assign ovf_f[rmj_pkg::LaneRngX + j] =
      (NR + 2 * DW)'(rng_num[j]) >= ((NR + 2 * DW)'(r_e_q) << DW);
    assign ovf_f[rmj_pkg::LaneBrgX + j] =
      (NB + 3 * DW)'(brg_num[j]) >= ((NB + 3 * DW)'(s_e_q) << DW);
    assign ovf_f[rmj_pkg::LaneRteX + j] =
      (NC + 4 * DW)'(rte_num[j]) >= ((NC + 4 * DW)'(sr_e_q) << DW);
  end

  always_comb begin
    ctl_f     = ctl_e_q;
    ctl_f.ovf = ovf_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_f_q <= '0;
    end else begin
      ctl_f_q <= ctl_f;
    end
  end

  always_ff @(posedge clk_i) begin
    rng_num_q <= rng_num;
    brg_num_q <= brg_num;
    rte_num_q <= rte_num;
    r_f_q     <= r_e_q;
    s_f_q     <= s_e_q;
    sr_f_q    <= sr_e_q;
  end

  // divider chain, one cell per quotient bit from the top down
  rmj_pkg::ctl_t          dv_ctl [DW+1];
  logic [DW-1:0]          dv_rd  [DW+1];
  logic [2*DW-1:0]        dv_bd  [DW+1];
  logic [3*DW-1:0]        dv_cd  [DW+1];
  logic [1:0][NR-1:0]     dv_rr  [DW+1];
  logic [1:0][NB-1:0]     dv_br  [DW+1];
  logic [1:0][NC-1:0]     dv_cr  [DW+1];
  logic [NL-1:0][DW-1:0]  dv_q   [DW+1];

  assign dv_ctl[0] = ctl_f_q;
  assign dv_rd[0]  = r_f_q;
  assign dv_bd[0]  = s_f_q;
  assign dv_cd[0]  = sr_f_q;
  assign dv_rr[0]  = rng_num_q;
  assign dv_br[0]  = brg_num_q;
  assign dv_cr[0]  = rte_num_q;
  assign dv_q[0]   = '0;

  for (genvar k = 0; k < DW; k++) begin : g_div
    rmj_div_cell #(
      .DW  (DW),
      .FW  (FW),
      .BIT (DW - 1 - k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (dv_ctl[k]),
      .rng_den_i (dv_rd[k]),
      .brg_den_i (dv_bd[k]),
      .rte_den_i (dv_cd[k]),
      .rng_rem_i (dv_rr[k]),
      .brg_rem_i (dv_br[k]),
      .rte_rem_i (dv_cr[k]),
      .quo_i     (dv_q[k]),
      .ctl_o     (dv_ctl[k+1]),
      .rng_den_o (dv_rd[k+1]),
      .brg_den_o (dv_bd[k+1]),
      .rte_den_o (dv_cd[k+1]),
      .rng_rem_o (dv_rr[k+1]),
      .brg_rem_o (dv_br[k+1]),
      .rte_rem_o (dv_cr[k+1]),
      .quo_o     (dv_q[k+1])
    );
  end

  // stage g: saturate, apply sign, zero the entries when too close
  rmj_pkg::ctl_t         ctl_g;
  logic [NL-1:0][DW-1:0] res_g;
  logic [NL-1:0][DW-1:0] res_q;
  logic                  vld_q;
  logic                  tc_q;

  assign ctl_g = dv_ctl[DW];

  for (genvar k = 0; k < NL; k++) begin : g_sat
    logic [DW-1:0] lim;
    logic [DW-1:0] mag;

    assign lim      = ctl_g.neg[k] ? HALF : (HALF - DW'(1));
    assign mag      = (ctl_g.ovf[k] || (dv_q[DW][k] > lim)) ? lim : dv_q[DW][k];
    assign res_g[k] = ctl_g.tc ? '0 : (ctl_g.neg[k] ? (~mag + DW'(1)) : mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctl_g.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_g;
    tc_q  <= ctl_g.tc;
  end

  assign result_valid_o = vld_q;
  assign too_close_o    = vld_q && tc_q;
  assign range_dpx_o    = res_q[rmj_pkg::LaneRngX];
  assign range_dpy_o    = res_q[rmj_pkg::LaneRngY];
  assign bearing_dpx_o  = res_q[rmj_pkg::LaneBrgX];
  assign bearing_dpy_o  = res_q[rmj_pkg::LaneBrgY];
  assign rate_dpx_o     = res_q[rmj_pkg::LaneRteX];
  assign rate_dpy_o     = res_q[rmj_pkg::LaneRteY];

  // negative range_dpx on the result port
  logic rng_neg_out;

  assign rng_neg_out = result_valid_o && range_dpx_o[DW-1];

  // checks
  `RMJ_ASSERT_IMP(a_res_follows_req, result_valid_o, $past(start_i, LAT), "result without request")
  `RMJ_ASSERT_IMP(a_tc_strobed, too_close_o, result_valid_o, "too_close outside a result")
  `RMJ_ASSERT_IMP(a_rng_sign, rng_neg_out, $past(pos_x_i[DW-1], LAT), "range_dpx sign off")
  `RMJ_ASSERT(a_vld_tracks_chain, vld_q == $past(dv_ctl[DW].vld), "valid out of step")

endmodule
